// ----- rtl/rtp_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none
package rtp_pkg;

  localparam int unsigned FracW   = 8;
  localparam int unsigned OctW    = 4;
  localparam int unsigned WholeW  = 22;
  localparam int unsigned DurW    = 23;
  localparam int unsigned PitchW  = 13;
  localparam int unsigned AccW    = 16;
  localparam int unsigned CfgIdxW = 2;
  localparam int unsigned CfgW    = 22;
  localparam int unsigned QDepth  = 2;

  localparam logic [CfgIdxW-1:0] CFG_DEF_FRAC = 2'd0;
  localparam logic [CfgIdxW-1:0] CFG_DEF_OCT  = 2'd1;
  localparam logic [CfgIdxW-1:0] CFG_WHOLE    = 2'd2;

  localparam logic [7:0] CH_SHARP = 8'h23;
  localparam logic [7:0] CH_DOT   = 8'h2e;
  localparam logic [7:0] CH_COMMA = 8'h2c;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] LOWER_MASK = 8'h20;
  localparam logic [OctW-1:0] MIN_OCT = 4'd3;
  localparam logic [OctW-1:0] MAX_OCT = 4'd8;
  localparam logic [PitchW-1:0] SOUND_MIN = 13'd100;

  typedef enum logic [2:0] {
    PH_FRAC, PH_SHARP, PH_DOTS1, PH_OCT, PH_DOTS2, PH_SKIP
  } phase_t;

  typedef enum logic [1:0] {
    OP_LETTER, OP_SHARP, OP_DOT, OP_EMIT
  } op_t;

  // command from the front part to the back part
  typedef struct packed {
    op_t             op;
    logic [AccW-1:0] acc;
    logic [3:0]      tidx;
    logic            rest;
    logic            done;
  } cmd_t;

  typedef enum logic [1:0] {
    BK_IDLE, BK_DIV, BK_OUT
  } bk_state_t;

  function automatic logic [PitchW-1:0] top_hz(input logic [3:0] i);
    logic [PitchW-1:0] r;
    unique case (i)
      4'd0: r = 13'd7040;
      4'd1: r = 13'd7459;
      4'd2: r = 13'd7902;
      4'd3: r = 13'd4186;
      4'd4: r = 13'd4435;
      4'd5: r = 13'd4699;
      4'd6: r = 13'd4978;
      4'd7: r = 13'd5274;
      4'd8: r = 13'd5588;
      4'd9: r = 13'd5920;
      4'd10: r = 13'd6272;
      default: r = 13'd6645;
    endcase
    return r;
  endfunction

  function automatic logic [3:0] letter_idx(input logic [7:0] l);
    logic [3:0] r;
    unique case (l)
      8'h61: r = 4'd0;
      8'h62: r = 4'd2;
      8'h63: r = 4'd3;
      8'h64: r = 4'd5;
      8'h65: r = 4'd7;
      8'h66: r = 4'd8;
      8'h67: r = 4'd10;
      8'h68: r = 4'd2;
      default: r = 4'd3;
    endcase
    return r;
  endfunction

endpackage
`default_nettype wire

// ----- rtl/rtp_if.sv -----
`timescale 1ns / 1ps
`default_nettype none
interface rtp_in_if;
  logic       valid;
  logic       ready;
  logic       kind;
  logic [7:0] char_code;
  modport source (output valid, kind, char_code, input ready);
  modport sink (input valid, kind, char_code, output ready);
endinterface

interface rtp_out_if;
  logic        valid;
  logic        ready;
  logic [12:0] pitch_hz;
  logic [22:0] duration_ms;
  logic        is_rest;
  logic        sounding;
  logic        tune_done;
  modport source (output valid, pitch_hz, duration_ms, is_rest, sounding, tune_done,
                  input ready);
  modport sink (input valid, pitch_hz, duration_ms, is_rest, sounding, tune_done,
                output ready);
endinterface
`default_nettype wire

// ----- rtl/rtp_front.sv -----
`timescale 1ns / 1ps
`default_nettype none
module rtp_front (
  input  wire logic          clk,
  input  wire logic          rst,
  rtp_in_if.sink             in_ch,
  output rtp_pkg::cmd_t      cmd,
  output logic               cmd_valid,
  input  wire logic          cmd_ready
);
  import rtp_pkg::*;

  phase_t          phase, phase_next;
  logic            started, started_next;
  logic [AccW-1:0] acc, acc_next;
  logic [3:0]      tidx, tidx_next;
  logic            rest, rest_next;
  logic            go;
  logic [7:0]      c, low;
  logic            eot, ws, dig, emit_cmd;
  logic [19:0]     acc10;
  logic [3:0]      lidx;

  assign c     = in_ch.char_code;
  assign eot   = in_ch.kind || (c == 8'h00);
  assign ws    = (c == CH_SPACE) || (c >= 8'h09 && c <= 8'h0d);
  assign dig   = (c >= 8'h30) && (c <= 8'h39);
  assign acc10 = {1'b0, acc, 3'b000} + {3'b000, acc, 1'b0} + {12'd0, c - 8'h30};
  assign low   = c | LOWER_MASK;
  assign lidx  = letter_idx(low);

  // emits a command only when the queue has room
  assign in_ch.ready = cmd_ready;
  assign go = in_ch.valid && cmd_ready;

  always_comb begin
    phase_next   = phase;
    started_next = started;
    acc_next     = acc;
    tidx_next    = tidx;
    rest_next    = rest;
    cmd_valid    = 1'b0;
    emit_cmd     = 1'b0;
    cmd          = '{op: OP_EMIT, acc: acc, tidx: tidx, rest: rest, done: eot};
    if (go) begin
      if (eot) begin
        if (phase != PH_FRAC || started) begin
          emit_cmd = 1'b1;
          if (phase == PH_FRAC) begin
            // only duration digits so far: close as letter c
            cmd = '{op: OP_LETTER, acc: acc, tidx: letter_idx(CH_SPACE), rest: 1'b0,
                    done: 1'b1};
          end
        end
      end else if (!ws) begin
        unique case (phase)
          PH_FRAC: begin
            if (dig) begin
              acc_next = (acc10 > 20'd65535) ? 16'hffff : acc10[15:0];
              started_next = 1'b1;
            end else begin
              cmd_valid = 1'b1;
              cmd = '{op: OP_LETTER, acc: acc, tidx: (low == 8'h70) ? 4'd0 : lidx,
                      rest: (low == 8'h70), done: 1'b0};
              tidx_next = (low == 8'h70) ? 4'd0 : lidx;
              rest_next = (low == 8'h70);
              acc_next = '0;
              started_next = 1'b1;
              phase_next = PH_SHARP;
            end
          end
          default: begin
            phase_t p;
            p = phase;
            if (p == PH_SHARP) begin
              p = PH_DOTS1;
              if (c == CH_SHARP) begin
                tidx_next = tidx + 4'd1;
                phase_next = PH_DOTS1;
              end
            end
            if (phase_next == phase) begin
              if (p == PH_DOTS1 && c == CH_DOT) begin
                cmd_valid = 1'b1;
                cmd.op = OP_DOT;
                phase_next = PH_DOTS1;
              end else begin
                if (p == PH_DOTS1) p = PH_OCT;
                if (p == PH_OCT && dig) begin
                  acc_next = (acc10 > 20'd65535) ? 16'hffff : acc10[15:0];
                  phase_next = PH_OCT;
                end else begin
                  if (p == PH_OCT) p = PH_DOTS2;
                  if (p == PH_DOTS2 && c == CH_DOT) begin
                    cmd_valid = 1'b1;
                    cmd.op = OP_DOT;
                    phase_next = PH_DOTS2;
                  end else begin
                    phase_next = PH_SKIP;
                    if (c == CH_COMMA) emit_cmd = 1'b1;
                  end
                end
              end
            end
          end
        endcase
      end
      if (emit_cmd) begin
        cmd_valid    = 1'b1;
        phase_next   = PH_FRAC;
        started_next = 1'b0;
        acc_next     = '0;
        tidx_next    = '0;
        rest_next    = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase   <= PH_FRAC;
      started <= 1'b0;
      acc     <= '0;
      tidx    <= '0;
      rest    <= 1'b0;
    end else begin
      phase   <= phase_next;
      started <= started_next;
      acc     <= acc_next;
      tidx    <= tidx_next;
      rest    <= rest_next;
    end
  end
endmodule
`default_nettype wire

// ----- rtl/rtp_queue.sv -----
`timescale 1ns / 1ps
`default_nettype none
module rtp_queue (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire rtp_pkg::cmd_t wr_data,
  input  wire logic          wr_valid,
  output logic               wr_ready,
  output rtp_pkg::cmd_t      rd_data,
  output logic               rd_valid,
  input  wire logic          rd_ready
);
  import rtp_pkg::*;

  cmd_t       mem [QDepth];
  logic [$clog2(QDepth)-1:0] wp, rp;
  logic [$clog2(QDepth):0]   cnt;
  logic       wr, rd;

  assign wr_ready = (cnt != QDepth[$clog2(QDepth):0]);
  assign rd_valid = (cnt != '0);
  assign rd_data  = mem[rp];
  assign wr = wr_valid && wr_ready;
  assign rd = rd_valid && rd_ready;

  always_ff @(posedge clk) begin
    if (wr) mem[wp] <= wr_data;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wp <= '0;
      rp <= '0;
      cnt <= '0;
    end else begin
      if (wr) wp <= wp + 1'b1;
      if (rd) rp <= rp + 1'b1;
      cnt <= cnt + {{$clog2(QDepth){1'b0}}, wr} - {{$clog2(QDepth){1'b0}}, rd};
    end
  end
endmodule
`default_nettype wire

// ----- rtl/rtp_back.sv -----
`timescale 1ns / 1ps
`default_nettype none
module rtp_back (
  input  wire logic                    clk,
  input  wire logic                    rst,
  input  wire rtp_pkg::cmd_t           cmd,
  input  wire logic                    cmd_valid,
  output logic                         cmd_ready,
  input  wire logic [rtp_pkg::FracW-1:0]  def_frac,
  input  wire logic [rtp_pkg::OctW-1:0]   def_oct,
  input  wire logic [rtp_pkg::WholeW-1:0] whole_ms,
  rtp_out_if.source                    out_ch
);
  import rtp_pkg::*;

  bk_state_t         st, st_next;
  logic [DurW-1:0]   dur, extra;
  logic [WholeW-1:0] quo, rem_dummy;
  logic [AccW:0]     rem;
  logic [AccW-1:0]   divisor;
  logic [4:0]        cnt;
  cmd_t              held;
  logic [AccW:0]     trial;
  logic [AccW-1:0]   oct_raw;
  logic [OctW-1:0]   oct;
  logic [PitchW-1:0] pitch;
  logic [3:0]        ti;

  assign rem_dummy = quo;
  assign trial = {rem[AccW-1:0], quo[WholeW-1]} - {1'b0, divisor};

  always_comb begin
    st_next = st;
    unique case (st)
      BK_IDLE: if (cmd_valid) begin
        if (cmd.op == OP_LETTER) st_next = BK_DIV;
        else if (cmd.op == OP_EMIT) st_next = BK_OUT;
      end
      BK_DIV: if (cnt == 5'd0) st_next = held.op == OP_EMIT || held.done ? BK_OUT : BK_IDLE;
      BK_OUT: if (out_ch.ready) st_next = BK_IDLE;
      default: st_next = BK_IDLE;
    endcase
  end

  assign cmd_ready = (st == BK_IDLE);

  always_comb begin
    oct_raw = (held.acc != '0) ? held.acc : {{(AccW-OctW){1'b0}}, def_oct};
    if (oct_raw < {12'd0, MIN_OCT}) oct = MIN_OCT;
    else if (oct_raw > {12'd0, MAX_OCT}) oct = MAX_OCT;
    else oct = oct_raw[OctW-1:0];
    ti = (held.tidx < 4'd12) ? held.tidx : 4'd11;
    pitch = held.rest ? '0 : (top_hz(ti) >> (MAX_OCT - oct));
  end

  assign out_ch.valid       = (st == BK_OUT);
  assign out_ch.pitch_hz    = pitch;
  assign out_ch.duration_ms = dur;
  assign out_ch.is_rest     = held.rest;
  assign out_ch.sounding    = (pitch >= SOUND_MIN);
  assign out_ch.tune_done   = held.done;

  // restoring divider, one quotient bit a cycle
  always_ff @(posedge clk) begin
    if (rst) begin
      st <= BK_IDLE;
    end else begin
      st <= st_next;
    end
    unique case (st)
      BK_IDLE: if (cmd_valid) begin
        unique case (cmd.op)
          OP_LETTER: begin
            divisor <= (cmd.acc != '0) ? cmd.acc : {8'd0, def_frac};
            quo <= whole_ms;
            rem <= '0;
            cnt <= 5'(WholeW);
            held <= '{op: cmd.op, acc: '0, tidx: cmd.tidx, rest: cmd.rest,
                      done: cmd.done};
          end
          OP_SHARP: held.tidx <= held.tidx + 4'd1;
          OP_DOT: begin
            extra <= extra >> 1;
            dur <= dur + (extra >> 1);
          end
          OP_EMIT: begin
            held.acc <= cmd.acc;
            held.rest <= cmd.rest;
            held.tidx <= cmd.tidx;
            held.done <= cmd.done;
            held.op <= cmd.op;
          end
          default: ;
        endcase
      end
      BK_DIV: begin
        if (cnt != 5'd0) begin
          cnt <= cnt - 5'd1;
          if (divisor == '0) begin
            quo <= '0;
          end else if (!trial[AccW]) begin
            rem <= trial;
            quo <= {quo[WholeW-2:0], 1'b1};
          end else begin
            rem <= {rem[AccW-1:0], quo[WholeW-1]};
            quo <= {quo[WholeW-2:0], 1'b0};
          end
        end else begin
          dur <= {1'b0, rem_dummy};
          extra <= {1'b0, rem_dummy};
        end
      end
      default: ;
    endcase
  end
endmodule
`default_nettype wire

// ----- rtl/rtttl_note_parser.sv -----
`timescale 1ns / 1ps
`default_nettype none
// a letter holds the back end through accept, 22 divider steps and write-back;
// dots are taken as they are accepted; a note's result waits in the output state until taken
// throughput: one character a cycle while the queue has room; a letter holds the
// back end for the 22-step restoring divider
// a note result enters the output state once its closing beat is taken, after the divider for a letter
// reset (rst, synchronous) clears parser phase, queue and back-end state, and
// loads the register defaults 4, 5 and 4000
module rtttl_note_parser (
  input  wire logic                        clk,
  input  wire logic                        rst,
  rtp_in_if.sink                           in_ch,
  rtp_out_if.source                        out_ch,
  input  wire logic                        cfg_we,
  input  wire logic [rtp_pkg::CfgIdxW-1:0] cfg_index,
  input  wire logic [rtp_pkg::CfgW-1:0]    cfg_data
);
  import rtp_pkg::*;

  logic [FracW-1:0]  def_frac;
  logic [OctW-1:0]   def_oct;
  logic [WholeW-1:0] whole_ms;
  cmd_t  f_cmd, q_cmd;
  logic  f_valid, f_ready, q_valid, q_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      def_frac <= 8'd4;
      def_oct  <= 4'd5;
      whole_ms <= 22'd4000;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_DEF_FRAC: def_frac <= cfg_data[FracW-1:0];
        CFG_DEF_OCT:  def_oct  <= cfg_data[OctW-1:0];
        CFG_WHOLE:    whole_ms <= cfg_data[WholeW-1:0];
        default: ;
      endcase
    end
  end

  rtp_front u_front (.clk, .rst, .in_ch, .cmd(f_cmd), .cmd_valid(f_valid),
                     .cmd_ready(f_ready));

  rtp_queue u_queue (.clk, .rst, .wr_data(f_cmd), .wr_valid(f_valid), .wr_ready(f_ready),
                     .rd_data(q_cmd), .rd_valid(q_valid), .rd_ready(q_ready));

  rtp_back u_back (.clk, .rst, .cmd(q_cmd), .cmd_valid(q_valid), .cmd_ready(q_ready),
                   .def_frac, .def_oct, .whole_ms, .out_ch);
endmodule
`default_nettype wire

// ----- test/rtttl_note_parser_test.sv -----
`timescale 1ns / 1ps
module rtttl_note_parser_test;
  import rtp_pkg::*;

  localparam int unsigned IdleLimit = 5000;
  localparam int unsigned SettleCycles = 40;

  typedef struct {
    logic [PitchW-1:0] pitch_hz;
    logic [DurW-1:0]   duration_ms;
    logic              is_rest;
    logic              sounding;
    logic              tune_done;
  } note_t;

  typedef struct {
    bit         kind;
    logic [7:0] ch;
    bit         has_note;
    note_t      note;
  } row_t;

  logic clk;
  logic rst;
  logic cfg_we;
  logic [CfgIdxW-1:0] cfg_index;
  logic [CfgW-1:0] cfg_data;

  rtp_in_if in_ch ();
  rtp_out_if out_ch ();

  rtttl_note_parser DUT (
    .clk       (clk),
    .rst       (rst),
    .in_ch     (in_ch),
    .out_ch    (out_ch),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always begin
    clk = 1'b1;
    #4;
    clk = 1'b0;
    #4;
  end

  // parser copy
  logic [FracW-1:0]  fraction_reg;
  logic [OctW-1:0]   octave_reg;
  logic [WholeW-1:0] whole_reg;
  phase_t            ph;
  bit                started;
  logic [AccW-1:0]   acc;
  logic [3:0]        tidx;
  bit                rest;
  logic [DurW-1:0]   run_dur;
  logic [DurW-1:0]   dot_ext;

  note_t pending_notes[$];
  int errors = 0;
  int chars_sent = 0;
  int notes_checked = 0;
  int settings_used = 0;

  int unsigned hz_top[12] = '{7040, 7459, 7902, 4186, 4435, 4699, 4978, 5274, 5588, 5920,
                              6272, 6645};
  int unsigned letter_pos[7] = '{0, 2, 3, 5, 7, 8, 10};

  function automatic void clear_note();
    ph = PH_FRAC;
    started = 0;
    acc = '0;
    tidx = '0;
    rest = 0;
    run_dur = '0;
    dot_ext = '0;
  endfunction

  function automatic void add_digit(logic [7:0] c);
    int unsigned v;
    v = acc * 10 + (c - 8'h30);
    acc = (v > 65535) ? 16'hffff : v[15:0];
  endfunction

  function automatic void add_dot();
    dot_ext = dot_ext >> 1;
    run_dur = run_dur + dot_ext;
  endfunction

  function automatic void take_letter(logic [7:0] c);
    int unsigned f;
    logic [7:0] l;
    f = (acc != 0) ? acc : fraction_reg;
    l = c | LOWER_MASK;
    run_dur = (f != 0) ? DurW'(whole_reg / f) : '0;
    dot_ext = run_dur;
    acc = '0;
    if (l == 8'h68) l = 8'h62;
    rest = (l == 8'h70);
    if (rest) begin
      tidx = '0;
    end else begin
      if (l < 8'h61 || l > 8'h67) l = 8'h63;
      tidx = 4'(letter_pos[l - 8'h61]);
    end
    started = 1;
    ph = PH_SHARP;
  endfunction

  function automatic note_t close_note(bit done);
    note_t r;
    int unsigned oct;
    int unsigned p;
    p = 0;
    if (!rest) begin
      oct = (acc != 0) ? acc : octave_reg;
      if (oct < MIN_OCT) oct = MIN_OCT;
      if (oct > MAX_OCT) oct = MAX_OCT;
      p = hz_top[(tidx < 12) ? tidx : 11] >> (MAX_OCT - oct);
    end
    r.pitch_hz = PitchW'(p);
    r.duration_ms = run_dur;
    r.is_rest = rest;
    r.sounding = (p >= SOUND_MIN);
    r.tune_done = done;
    clear_note();
    return r;
  endfunction

  function automatic bit is_digit(logic [7:0] c);
    return c >= 8'h30 && c <= 8'h39;
  endfunction

  function automatic bit parse_char(bit k, logic [7:0] c, output note_t r);
    if (k || c == 8'h00) begin
      if (ph == PH_FRAC) begin
        if (!started) return 0;
        take_letter(CH_SPACE);
      end
      r = close_note(1);
      return 1;
    end
    if (c == CH_SPACE || (c >= 8'h09 && c <= 8'h0d)) return 0;
    if (ph == PH_FRAC) begin
      if (is_digit(c)) begin
        add_digit(c);
        started = 1;
      end else begin
        take_letter(c);
      end
      return 0;
    end
    if (ph == PH_SHARP) begin
      ph = PH_DOTS1;
      if (c == CH_SHARP) begin
        tidx = tidx + 4'd1;
        return 0;
      end
    end
    if (ph == PH_DOTS1) begin
      if (c == CH_DOT) begin
        add_dot();
        return 0;
      end
      ph = PH_OCT;
    end
    if (ph == PH_OCT) begin
      if (is_digit(c)) begin
        add_digit(c);
        return 0;
      end
      ph = PH_DOTS2;
    end
    if (ph == PH_DOTS2) begin
      if (c == CH_DOT) begin
        add_dot();
        return 0;
      end
      ph = PH_SKIP;
    end
    if (c == CH_COMMA) begin
      r = close_note(0);
      return 1;
    end
    return 0;
  endfunction

  function automatic int unsigned pick_gap();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(10, 60);
  endfunction

  // send one beat, keep valid up when the next beat follows at once
  task automatic send_beat(bit k, logic [7:0] c, bit has_typed, note_t typed);
    int unsigned gap;
    note_t r;
    bit got;
    gap = pick_gap();
    if (gap > 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_ch.valid <= 1'b1;
    in_ch.kind <= k;
    in_ch.char_code <= c;
    do @(posedge clk); while (!in_ch.ready);
    chars_sent++;
    got = parse_char(k, c, r);
    if (has_typed) pending_notes.push_back(typed);
    else if (got) pending_notes.push_back(r);
  endtask

  task automatic send_char(bit k, logic [7:0] c);
    note_t none;
    send_beat(k, c, 0, none);
  endtask

  task automatic drain();
    in_ch.valid <= 1'b0;
    @(posedge clk);
    while (pending_notes.size() != 0) @(posedge clk);
    repeat (SettleCycles) @(posedge clk);
  endtask

  task automatic write_reg(logic [CfgIdxW-1:0] idx, logic [CfgW-1:0] val);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    case (idx)
      CFG_DEF_FRAC: fraction_reg = val[FracW-1:0];
      CFG_DEF_OCT:  octave_reg = val[OctW-1:0];
      CFG_WHOLE:    whole_reg = val[WholeW-1:0];
      default: ;
    endcase
  endtask

  task automatic set_regs(int unsigned f, int unsigned o, int unsigned w);
    write_reg(CFG_DEF_FRAC, CfgW'(f));
    write_reg(CFG_DEF_OCT, CfgW'(o));
    write_reg(CFG_WHOLE, CfgW'(w));
    cfg_we <= 1'b0;
    @(posedge clk);
    settings_used++;
  endtask

  function automatic logic [7:0] pick_space();
    int unsigned r;
    r = $urandom_range(0, 5);
    return (r == 5) ? CH_SPACE : 8'(8'h09 + r);
  endfunction

  task automatic send_number(int unsigned n);
    string s;
    s = $sformatf("%0d", n);
    for (int i = 0; i < s.len(); i++) begin
      send_char(0, s[i]);
      if ($urandom_range(0, 19) == 0) send_char(0, pick_space());
    end
  endtask

  // one note of random content, mostly well formed
  task automatic send_note();
    string letters;
    int unsigned r;
    int unsigned fr[6] = '{1, 2, 4, 8, 16, 32};
    letters = "abcdefghpABCDEFGHP";
    if ($urandom_range(0, 9) == 0) send_char(0, pick_space());
    r = $urandom_range(0, 19);
    if (r < 12) send_number(fr[$urandom_range(0, 5)]);
    else if (r < 15) send_number($urandom_range(0, 999));
    else if (r == 15) send_number($urandom_range(65536, 999999));
    if ($urandom_range(0, 9) == 0) send_char(0, 8'($urandom_range(1, 255)));
    else send_char(0, letters[$urandom_range(0, letters.len() - 1)]);
    if ($urandom_range(0, 2) == 0) send_char(0, CH_SHARP);
    repeat ($urandom_range(0, 3) == 0 ? $urandom_range(1, 3) : 0) send_char(0, CH_DOT);
    r = $urandom_range(0, 9);
    if (r < 7) send_number($urandom_range(0, 9));
    else if (r == 7) send_number($urandom_range(10, 99));
    repeat ($urandom_range(0, 3) == 0 ? $urandom_range(1, 3) : 0) send_char(0, CH_DOT);
    if ($urandom_range(0, 9) == 0) send_char(0, 8'($urandom_range(1, 255)));
    r = $urandom_range(0, 29);
    if (r == 0) send_char(1, 8'($urandom_range(0, 255)));
    else if (r == 1) send_char(0, 8'h00);
    else send_char(0, CH_COMMA);
  endtask

  task automatic random_phase(int unsigned n);
    int unsigned start;
    start = chars_sent;
    while (chars_sent - start < n) begin
      if ($urandom_range(0, 9) < 8) send_note();
      else send_char($urandom_range(0, 7) == 0, 8'($urandom_range(0, 255)));
    end
    send_char(1, 8'($urandom_range(0, 255)));
    drain();
  endtask

  function automatic note_t mk(int unsigned p, int unsigned d, bit r, bit s, bit t);
    note_t n;
    n.pitch_hz = PitchW'(p);
    n.duration_ms = DurW'(d);
    n.is_rest = r;
    n.sounding = s;
    n.tune_done = t;
    return n;
  endfunction

  // result side: random stalls and the check
  int unsigned stall_left = 0;
  always @(posedge clk) begin
    note_t want;
    if (rst) begin
      out_ch.ready <= 1'b0;
    end else begin
      if (out_ch.valid && out_ch.ready) begin
        if (pending_notes.size() == 0) begin
          $display("%0t unexpected note: got pitch %0d duration %0d", $time,
                   out_ch.pitch_hz, out_ch.duration_ms);
          errors++;
        end else begin
          want = pending_notes.pop_front();
          notes_checked++;
          if (out_ch.pitch_hz !== want.pitch_hz) begin
            $display("%0t pitch_hz: expected %0d actual %0d", $time, want.pitch_hz,
                     out_ch.pitch_hz);
            errors++;
          end
          if (out_ch.duration_ms !== want.duration_ms) begin
            $display("%0t duration_ms: expected %0d actual %0d", $time, want.duration_ms,
                     out_ch.duration_ms);
            errors++;
          end
          if (out_ch.is_rest !== want.is_rest) begin
            $display("%0t is_rest: expected %0d actual %0d", $time, want.is_rest,
                     out_ch.is_rest);
            errors++;
          end
          if (out_ch.sounding !== want.sounding) begin
            $display("%0t sounding: expected %0d actual %0d", $time, want.sounding,
                     out_ch.sounding);
            errors++;
          end
          if (out_ch.tune_done !== want.tune_done) begin
            $display("%0t tune_done: expected %0d actual %0d", $time, want.tune_done,
                     out_ch.tune_done);
            errors++;
          end
        end
      end
      if (stall_left > 0) begin
        out_ch.ready <= 1'b0;
        stall_left--;
      end else begin
        out_ch.ready <= 1'b1;
        if ($urandom_range(0, 3) == 0) stall_left = pick_gap();
      end
    end
  end

  int unsigned idle_cycles = 0;
  always @(posedge clk) begin
    if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= IdleLimit) begin
      $display("%0t watchdog: no beat for %0d cycles", $time, idle_cycles);
      $display("rtttl_note_parser verification failed");
      $finish;
    end
  end

  row_t rows[$];

  initial begin
    rst <= 1'b1;
    cfg_we <= 1'b0;
    cfg_index <= '0;
    cfg_data <= '0;
    in_ch.valid <= 1'b0;
    in_ch.kind <= 1'b0;
    in_ch.char_code <= '0;
    fraction_reg = 4;
    octave_reg = 5;
    whole_reg = 4000;
    clear_note();
    repeat (4) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // rest
    rows.push_back('{0, "p", 0, mk(0, 0, 0, 0, 0)});
    rows.push_back('{0, ",", 1, mk(0, 1000, 1, 0, 0)});
    // sharp on b, then a trailing dot
    rows.push_back('{0, "b", 0, mk(0, 0, 0, 0, 0)});
    rows.push_back('{0, "#", 0, mk(0, 0, 0, 0, 0)});
    rows.push_back('{0, "6", 0, mk(0, 0, 0, 0, 0)});
    rows.push_back('{0, ".", 0, mk(0, 0, 0, 0, 0)});
    rows.push_back('{0, ",", 1, mk(1046, 1500, 0, 1, 0)});
    // saturated fraction, h as b, octave above the top
    repeat (5) rows.push_back('{0, "9", 0, mk(0, 0, 0, 0, 0)});
    rows.push_back('{0, "h", 0, mk(0, 0, 0, 0, 0)});
    rows.push_back('{0, "9", 0, mk(0, 0, 0, 0, 0)});
    rows.push_back('{0, ",", 1, mk(7902, 0, 0, 1, 0)});
    // end of tune with nothing open
    rows.push_back('{1, 8'hff, 0, mk(0, 0, 0, 0, 0)});
    // only digits, then end of tune
    rows.push_back('{0, "1", 0, mk(0, 0, 0, 0, 0)});
    rows.push_back('{0, "6", 0, mk(0, 0, 0, 0, 0)});
    rows.push_back('{1, 8'h00, 1, mk(523, 250, 0, 1, 1)});
    // comma taken as the letter
    rows.push_back('{0, ",", 0, mk(0, 0, 0, 0, 0)});
    rows.push_back('{0, ",", 1, mk(523, 1000, 0, 1, 0)});
    // whitespace, then character zero as end of tune
    rows.push_back('{0, 8'h20, 0, mk(0, 0, 0, 0, 0)});
    rows.push_back('{0, 8'h09, 0, mk(0, 0, 0, 0, 0)});
    rows.push_back('{0, "E", 0, mk(0, 0, 0, 0, 0)});
    rows.push_back('{0, 8'h00, 1, mk(659, 1000, 0, 1, 1)});
    foreach (rows[i]) send_beat(rows[i].kind, rows[i].ch, rows[i].has_note, rows[i].note);
    drain();
    settings_used++;

    random_phase(300);
    set_regs(255, 8, 4194303);
    random_phase(300);
    set_regs(1, 3, 1);
    random_phase(250);
    set_regs(0, 0, 4194303);
    random_phase(200);
    set_regs(8'($urandom_range(1, 255)), 15, 22'($urandom_range(1, 4194303)));
    random_phase(250);
    set_regs(8'($urandom_range(1, 32)), 4'($urandom_range(3, 8)),
             22'($urandom_range(500, 20000)));
    random_phase(400);

    $display("sent %0d characters under %0d register settings, checked %0d notes",
             chars_sent, settings_used, notes_checked);
    if (errors == 0 && pending_notes.size() == 0) begin
      $display("rtttl_note_parser verification clean");
    end else begin
      $display("%0d mismatches, %0d notes never came", errors, pending_notes.size());
      $display("rtttl_note_parser verification failed");
    end
    $finish;
  end
endmodule
